// File: rtl/core/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg - ultrasonic echo ranger shared definitions
// Action and status codes, timing constants and the registered item type
// passed from the input stage to the core.
// ----------------------------------------------------------------------------
package uer_pkg;

  // Field widths
  localparam int unsigned TimeW  = 26;
  localparam int unsigned TmoMsW = 16;
  localparam int unsigned CountW = 4;

  // Trigger pulse length in microsecond ticks (1 to 15)
  localparam logic [CountW-1:0] TrigUs = 4'd10;

  // Milliseconds to microseconds
  localparam logic [TimeW-1:0] MsToUs = 26'd1000;

  typedef enum logic [1:0] {
    ActTick  = 2'd0,
    ActStart = 2'd1,
    ActEcho  = 2'd2,
    ActPoll  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    StIdle  = 2'd0,
    StBusy  = 2'd1,
    StError = 2'd2
  } status_e;

  // Item held in the input register, timeout already scaled to microseconds
  typedef struct packed {
    action_e            action;
    logic [TimeW-1:0]   timeout_us;
    logic               echo_level;
  } item_t;

endpackage

// File: rtl/core/uer_if.sv
// ----------------------------------------------------------------------------
// uer_if - ranger channel interfaces
// Valid/ready channels for the input words and the result words.
// ----------------------------------------------------------------------------
interface uer_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] tmo_ms;
  logic        echo_level;

  modport source (output valid, action, tmo_ms, echo_level, input ready);
  modport sink   (input valid, action, tmo_ms, echo_level, output ready);
endinterface

interface uer_out_if;
  logic        valid;
  logic        ready;
  logic        trigger_out;
  logic        available;
  logic [1:0]  status;
  logic [25:0] width_us;

  modport source (output valid, trigger_out, available, status, width_us, input ready);
  modport sink   (input valid, trigger_out, available, status, width_us, output ready);
endinterface

// File: rtl/core/uer_in_stage.sv
// ----------------------------------------------------------------------------
// uer_in_stage - input register
// Captures an input word and scales the timeout from ms to us on the way in.
// ----------------------------------------------------------------------------
module uer_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  uer_in_if.sink         in_i,
  input  logic           take_i,
  output logic           item_valid_o,
  output uer_pkg::item_t item_o
);
  import uer_pkg::*;

  logic  valid_q;
  item_t item_q;
  logic  load;

  // Register is free when empty or being drained this cycle
  assign in_i.ready = !valid_q || take_i;
  assign load       = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  // Payload, timeout scaled by 1000 (always fits in 26 bits)
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.action     <= action_e'(in_i.action);
      item_q.timeout_us <= TimeW'(in_i.tmo_ms) * MsToUs;
      item_q.echo_level <= in_i.echo_level;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// File: rtl/core/uer_core.sv
// ----------------------------------------------------------------------------
// uer_core - measurement state and result register
// Applies one item to the ranger state and registers the result word.
// ----------------------------------------------------------------------------
module uer_core #(
  parameter logic [uer_pkg::CountW-1:0] TrigPulseUs = uer_pkg::TrigUs
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_valid_i,
  input  uer_pkg::item_t item_i,
  output logic           take_o,
  uer_out_if.source      out_o
);
  import uer_pkg::*;

  typedef enum logic [2:0] {
    MIdle   = 3'd0,
    MTrig   = 3'd1,
    MWStart = 3'd2,
    MWStop  = 3'd3,
    MError  = 3'd4
  } mode_e;

  mode_e             mode_q, mode_d;
  logic [TimeW-1:0]  now_q, now_d;
  logic [TimeW-1:0]  trig_q, trig_d;
  logic [TimeW-1:0]  echo_q, echo_d;
  logic [TimeW-1:0]  tmo_q, tmo_d;
  logic [TimeW-1:0]  meas_q, meas_d;
  logic [CountW-1:0] pulse_q, pulse_d;
  logic [TimeW-1:0]  elapsed;
  logic              pending;
  status_e           status;

  logic              out_valid_q;
  logic              trig_out_q;
  logic              avail_q;
  status_e           status_q;
  logic [TimeW-1:0]  width_q;

  // Advance when the result register is free or being read
  assign take_o = item_valid_i && (!out_valid_q || out_o.ready);

  // Next state for the item in the input register
  always_comb begin
    mode_d  = mode_q;
    now_d   = now_q;
    trig_d  = trig_q;
    echo_d  = echo_q;
    tmo_d   = tmo_q;
    meas_d  = meas_q;
    pulse_d = pulse_q;
    if (take_o) begin
      unique case (item_i.action)
        ActTick: begin
          now_d = now_q + TimeW'(1);
          if (mode_q == MTrig) begin
            pulse_d = pulse_q + CountW'(1);
            if (pulse_d >= TrigPulseUs) begin
              mode_d = MWStart;
            end
          end
        end
        ActStart: begin
          mode_d  = MTrig;
          trig_d  = now_q;
          tmo_d   = item_i.timeout_us;
          pulse_d = '0;
        end
        ActEcho: begin
          if (mode_q == MWStart) begin
            if (item_i.echo_level) begin
              echo_d = now_q;
              mode_d = MWStop;
            end else begin
              mode_d = MError;
            end
          end else if (mode_q == MWStop) begin
            if (!item_i.echo_level) begin
              meas_d = now_q - echo_q;
              mode_d = MIdle;
            end else begin
              mode_d = MError;
            end
          end
        end
        ActPoll: ;
        default: ;
      endcase
    end
    // Timeout while trigger or echo is pending, modulo 2^26 elapsed time
    elapsed = now_d - trig_d;
    if (take_o && (mode_d == MTrig || mode_d == MWStart || mode_d == MWStop) &&
        elapsed > tmo_d) begin
      mode_d = MError;
    end
  end

  assign pending = (mode_d == MTrig) || (mode_d == MWStart) || (mode_d == MWStop);

  // Status after the item; unused mode codes read as error
  always_comb begin
    if (mode_d == MIdle) begin
      status = StIdle;
    end else if (pending) begin
      status = StBusy;
    end else begin
      status = StError;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MIdle;
      now_q       <= '0;
      trig_q      <= '0;
      echo_q      <= '0;
      tmo_q       <= '0;
      meas_q      <= '0;
      pulse_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      now_q   <= now_d;
      trig_q  <= trig_d;
      echo_q  <= echo_d;
      tmo_q   <= tmo_d;
      meas_q  <= meas_d;
      pulse_q <= pulse_d;
      if (take_o) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result word
  always_ff @(posedge clk_i) begin
    if (take_o) begin
      trig_out_q <= (mode_d == MTrig);
      avail_q    <= (status != StBusy);
      status_q   <= status;
      width_q    <= (mode_d == MIdle) ? meas_d : '0;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.trigger_out = trig_out_q;
  assign out_o.available   = avail_q;
  assign out_o.status      = status_q;
  assign out_o.width_us    = width_q;

`ifndef SYNTHESIS
  a_trig_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && trig_out_q |-> status_q == StBusy)
    else $error("trigger driven outside busy status");

  a_width_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (width_q != '0) |-> status_q == StIdle)
    else $error("width reported while not idle");

  a_avail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> avail_q == (status_q != StBusy))
    else $error("available disagrees with status");

  a_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MTrig |-> pulse_q < TrigPulseUs)
    else $error("trigger pulse overran");

  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o |=> out_valid_q)
    else $error("result word lost");
`endif

endmodule

// File: rtl/core/ultrasonic_echo_ranger.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger - ultrasonic range sensor controller
//
//   channel  dir  word
//   in_i     in   action, tmo_ms, echo_level
//   out_o    out  trigger_out, available, status, width_us
//
// Each word waits in the input register; the state update runs between
// it and the result register, which registers its result.
// One word is accepted every cycle unless the result register stalls;
// the state update is a single pass.
// Reset leaves the ranger idle with a zero stored width.
// A stalled result register stops the input register; a new word is still
// taken in the cycle the waiting result is read.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger #(
  parameter logic [uer_pkg::CountW-1:0] TrigPulseUs = uer_pkg::TrigUs
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  uer_in_if.sink     in_i,
  uer_out_if.source  out_o
);
  import uer_pkg::*;

  logic  item_valid;
  item_t item;
  logic  take;

  uer_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  uer_core #(
    .TrigPulseUs (TrigPulseUs)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .take_o       (take),
    .out_o        (out_o)
  );

endmodule

// File: tb/sv/uer_ranging_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uer_ranging_checker - result checker for the ultrasonic echo ranger
// Watches the input and result channels, keeps its own copy of the ranger
// state, works out the report due for every accepted input word and
// compares each result word with the oldest report still due.
// ----------------------------------------------------------------------------
module uer_ranging_checker
  import uer_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  uer_in_if    in_i,
  uer_out_if   out_i,
  output int   fail_count_o,
  output int   pending_o
);

  // Measurement phases of the ranger
  typedef enum logic [2:0] {
    ModeIdle     = 3'd0,
    ModeTrigger  = 3'd1,
    ModeWaitRise = 3'd2,
    ModeWaitFall = 3'd3,
    ModeError    = 3'd4
  } ranger_mode_e;

  typedef struct packed {
    logic             trigger_out;
    logic             available;
    status_e          status;
    logic [TimeW-1:0] width_us;
  } range_report_t;

  ranger_mode_e      mode_q        = ModeIdle;
  logic [TimeW-1:0]  now_us_q      = '0;
  logic [TimeW-1:0]  trig_start_q  = '0;
  logic [TimeW-1:0]  echo_start_q  = '0;
  logic [TimeW-1:0]  timeout_us_q  = '0;
  logic [TimeW-1:0]  width_us_q    = '0;
  logic [CountW-1:0] pulse_count_q = '0;

  range_report_t reports_due[$];
  int            mismatches = 0;

  // Apply one word to the ranger state and return the report it yields
  function automatic range_report_t predict_ranging(action_e act, logic [TmoMsW-1:0] tmo_ms,
                                                    logic level);
    range_report_t    rep;
    logic [TimeW-1:0] elapsed;
    logic             pending;

    case (act)
      ActTick: begin
        now_us_q = now_us_q + TimeW'(1);
        if (mode_q == ModeTrigger) begin
          pulse_count_q = pulse_count_q + CountW'(1);
          if (pulse_count_q >= TrigUs) mode_q = ModeWaitRise;
        end
      end
      ActStart: begin
        mode_q        = ModeTrigger;
        trig_start_q  = now_us_q;
        timeout_us_q  = TimeW'(TimeW'(tmo_ms) * MsToUs);
        pulse_count_q = '0;
      end
      ActEcho: begin
        if (mode_q == ModeWaitRise) begin
          if (level) begin
            echo_start_q = now_us_q;
            mode_q       = ModeWaitFall;
          end else begin
            mode_q = ModeError;
          end
        end else if (mode_q == ModeWaitFall) begin
          if (!level) begin
            width_us_q = now_us_q - echo_start_q;
            mode_q     = ModeIdle;
          end else begin
            mode_q = ModeError;
          end
        end
      end
      default: ;
    endcase

    // Timeout runs from the start time, only while something is pending
    elapsed = now_us_q - trig_start_q;
    pending = (mode_q == ModeTrigger) || (mode_q == ModeWaitRise) || (mode_q == ModeWaitFall);
    if (pending && elapsed > timeout_us_q) begin
      mode_q  = ModeError;
      pending = 1'b0;
    end

    rep.trigger_out = (mode_q == ModeTrigger);
    rep.status      = (mode_q == ModeIdle) ? StIdle : (pending ? StBusy : StError);
    rep.available   = (rep.status != StBusy);
    rep.width_us    = (mode_q == ModeIdle) ? width_us_q : '0;
    return rep;
  endfunction

  function automatic void report_mismatch(string what, range_report_t want, range_report_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] %s: expected trig=%0b avail=%0b status=%0d width=%0d",
               $time, what, want.trigger_out, want.available, want.status, want.width_us);
      $display("    got trig=%0b avail=%0b status=%0d width=%0d",
               got.trigger_out, got.available, got.status, got.width_us);
    end
  endfunction

  // Compare result words, then queue the report for a newly accepted word
  always @(posedge clk_i or negedge rst_ni) begin
    range_report_t got;
    range_report_t want;

    if (!rst_ni) begin
      mode_q        <= ModeIdle;
      now_us_q      <= '0;
      trig_start_q  <= '0;
      echo_start_q  <= '0;
      timeout_us_q  <= '0;
      width_us_q    <= '0;
      pulse_count_q <= '0;
      reports_due.delete();
      pending_o     <= 0;
    end else begin
      if (out_i.valid && out_i.ready) begin
        got.trigger_out = out_i.trigger_out;
        got.available   = out_i.available;
        got.status      = status_e'(out_i.status);
        got.width_us    = out_i.width_us;
        if (reports_due.size() == 0) begin
          report_mismatch("unexpected result word", '0, got);
        end else begin
          want = reports_due.pop_front();
          if (got.trigger_out !== want.trigger_out || got.available !== want.available ||
              got.status !== want.status || got.width_us !== want.width_us)
            report_mismatch("result mismatch", want, got);
        end
      end
      if (in_i.valid && in_i.ready)
        reports_due.push_back(predict_ranging(action_e'(in_i.action), in_i.tmo_ms,
                                              in_i.echo_level));
      pending_o <= reports_due.size();
    end
  end

  assign fail_count_o = mismatches;

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - ultrasonic echo ranger regression
// Drives directed and random measurement sequences (start, trigger ticks,
// echo edges, polls) mixed with noise words, with random idling on both
// channels and one long result hold-off, and gives the final verdict from
// the checker's mismatch and pending-report counts.
// ----------------------------------------------------------------------------
module testbench;
  import uer_pkg::*;

  localparam int CycleLimit  = 300000;
  localparam int RandomWords = 550;
  localparam int DrainCycles = 10;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int   cycle_count   = 0;
  int   words_sent    = 0;
  bit   quiet_sender  = 0;
  bit   pressure_done = 0;
  int   fail_count;
  int   reports_pending;

  uer_in_if  word_in ();
  uer_out_if word_out ();

  ultrasonic_echo_ranger uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (word_in.sink),
    .out_o  (word_out.source)
  );

  uer_ranging_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (word_in),
    .out_i        (word_out),
    .fail_count_o (fail_count),
    .pending_o    (reports_pending)
  );

  always #1 clk_i = ~clk_i;

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("ultrasonic_echo_ranger regression: fail");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Offer one word and wait for it to be taken
  task automatic send_word(input action_e act, input logic [15:0] tmo, input logic level);
    int gap;
    gap = quiet_sender ? 0 : pick_gap();
    if (gap > 0) begin
      word_in.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    word_in.valid      <= 1'b1;
    word_in.action     <= act;
    word_in.tmo_ms     <= tmo;
    word_in.echo_level <= level;
    do begin
      @(posedge clk_i);
    end while (!word_in.ready);
    words_sent++;
  endtask

  // Microsecond ticks with the odd poll or stray echo mixed in
  task automatic send_ticks(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 19);
      if (r == 0) send_word(ActPoll, 16'($urandom), 1'($urandom));
      else if (r == 1) send_word(ActEcho, 16'($urandom), 1'($urandom));
      send_word(ActTick, 16'($urandom), 1'($urandom));
    end
  endtask

  // Result side: random stalls, one long hold-off to fill the ranger
  initial begin
    int hold;
    int run;
    word_out.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!pressure_done && words_sent >= 150) begin
        hold          = 120;
        pressure_done = 1;
      end else begin
        hold = ($urandom_range(0, 4) == 0) ? 0 : pick_gap();
      end
      if (hold > 0) begin
        word_out.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      word_out.ready <= 1'b1;
      run = $urandom_range(1, 16);
      repeat (run) @(posedge clk_i);
    end
  end

  // Stimulus and verdict
  initial begin
    int          target;
    int          r;
    logic [15:0] tmo;

    word_in.valid      <= 1'b0;
    word_in.action     <= ActPoll;
    word_in.tmo_ms     <= '0;
    word_in.echo_level <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: idle after reset, ignored echoes, restart, zero timeout,
    // full trigger pulse, rising edge, wrong level while waiting to fall
    send_word(ActPoll, 16'h0000, 1'b0);
    send_word(ActEcho, 16'hFFFF, 1'b1);
    send_word(ActStart, 16'hFFFF, 1'b0);
    send_word(ActEcho, 16'h0000, 1'b0);
    send_word(ActStart, 16'h0000, 1'b1);
    send_word(ActPoll, 16'hFFFF, 1'b1);
    send_word(ActTick, 16'h0000, 1'b0);
    send_word(ActEcho, 16'h0000, 1'b1);
    send_word(ActStart, 16'h8000, 1'b0);
    repeat (10) send_word(ActTick, 16'h0000, 1'b0);
    send_word(ActEcho, 16'h0000, 1'b1);
    send_word(ActTick, 16'hFFFF, 1'b1);
    send_word(ActTick, 16'h0000, 1'b0);
    send_word(ActEcho, 16'h0000, 1'b1);

    // Random measurement sequences with noise bursts between them
    target = words_sent + RandomWords;
    while (words_sent < target) begin
      quiet_sender = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 4))
          send_word(action_e'($urandom_range(0, 3)), 16'($urandom), 1'($urandom));
        continue;
      end
      r = $urandom_range(0, 9);
      tmo = (r == 0) ? 16'h0000 : (r == 1) ? 16'($urandom_range(1, 3)) : 16'($urandom);
      send_word(ActStart, tmo, 1'($urandom));
      if ($urandom_range(0, 9) == 0) send_word(ActStart, 16'($urandom), 1'($urandom));
      send_ticks($urandom_range(0, 9) == 0 ? $urandom_range(0, 9) : $urandom_range(10, 12));
      // Rising edge, occasionally of the wrong level
      send_word(ActEcho, 16'($urandom), ($urandom_range(0, 9) != 0));
      r = $urandom_range(0, 49);
      send_ticks(r == 0 ? $urandom_range(60, 120) : $urandom_range(0, 25));
      // Falling edge, occasionally of the wrong level
      send_word(ActEcho, 16'($urandom), ($urandom_range(0, 9) == 0));
      send_word(ActPoll, 16'($urandom), 1'($urandom));
    end
    word_in.valid <= 1'b0;

    // Let the checker count the last accepted word before draining
    @(posedge clk_i);
    while (reports_pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0 && reports_pending == 0)
      $display("ultrasonic_echo_ranger regression: pass");
    else
      $display("ultrasonic_echo_ranger regression: fail");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/uer_pkg.sv
rtl/core/uer_if.sv
rtl/core/uer_in_stage.sv
rtl/core/uer_core.sv
rtl/core/ultrasonic_echo_ranger.sv
tb/sv/uer_ranging_checker.sv
tb/sv/testbench.sv
